// File: hdl/assert_macros.svh
// Assertion macros shared by the bounded deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BDQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bounded deque check failed");
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bounded deque check failed");
`else
`define BDQ_ASSERT(lbl, clk, rst, prop)
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hdl/bdq_pkg.sv
// Types and codes of the bounded deque.
package bdq_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned OCC_W    = 5;
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DUMP       = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] element;
      logic                      is_last;
      logic [STATUS_W-1:0]       status;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_PUSH_FRONT,
      CMD_PUSH_BACK,
      CMD_POP_FRONT,
      CMD_ROTATE
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } ctrl_state_type;

endpackage

// File: hdl/bounded_deque_unit.sv
// Bounded deque top level: row of DEPTH cells plus sequencer.
// Push and pop: result registered, in the cycle after the start beat; one action per cycle while not busy.
// Dump of n stored words: busy while in the dump state, n results on consecutive
//   cycles, each registered from one dump beat; empty dump gives one result.
// The cell row rotates one place per dump beat, so the walk sets the dump rate.
// Reset clears the count and control state; cell contents are not cleared.
// The receiver cannot stall the result strobe.
module bounded_deque_unit #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  bdq_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output bdq_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(DEPTH);

   bdq_pkg::cell_cmd_type              cmd;
   logic [IDX_W-1:0]                   target;
   logic [DATA_WIDTH-1:0]              push_word;
   logic signed [bdq_pkg::VALUE_W-1:0] head_elem;
   logic [DATA_WIDTH-1:0]              cell_q     [DEPTH];
   logic [DATA_WIDTH-1:0]              left_data  [DEPTH];
   logic [DATA_WIDTH-1:0]              right_data [DEPTH];

   assign push_word = DATA_WIDTH'(req_data.value);
   assign head_elem = bdq_pkg::VALUE_W'(signed'(cell_q[0]));

   bdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .head_elem (head_elem),
      .busy      (busy),
      .cmd       (cmd),
      .target    (target),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_data[i] = '0;
      end else begin : g_mid
         assign left_data[i] = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data[i] = '0;
      end else begin : g_body
         assign right_data[i] = cell_q[i+1];
      end

      bdq_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .target     (target),
         .word       (push_word),
         .from_left  (left_data[i]),
         .from_right (right_data[i]),
         .head       (cell_q[0]),
         .q          (cell_q[i])
      );
   end

endmodule

// File: hdl/bdq_cell.sv
// One storage cell of the deque row; front of the deque sits in cell 0.
module bdq_cell #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned IDX_W      = 4,
   parameter int unsigned INDEX      = 0
) (
   input  logic                   clock,
   input  bdq_pkg::cell_cmd_type  cmd,
   input  logic [IDX_W-1:0]       target,
   input  logic [DATA_WIDTH-1:0]  word,
   input  logic [DATA_WIDTH-1:0]  from_left,
   input  logic [DATA_WIDTH-1:0]  from_right,
   input  logic [DATA_WIDTH-1:0]  head,
   output logic [DATA_WIDTH-1:0]  q
);

   logic [DATA_WIDTH-1:0] cell_ff;
   logic [DATA_WIDTH-1:0] cell_in;
   logic                  hit;

   assign hit = (target == IDX_W'(INDEX));

   always_comb begin
      unique case (cmd)
         bdq_pkg::CMD_HOLD:       cell_in = cell_ff;
         bdq_pkg::CMD_PUSH_FRONT: cell_in = (INDEX == 0) ? word : from_left;
         bdq_pkg::CMD_PUSH_BACK:  cell_in = hit ? word : cell_ff;
         bdq_pkg::CMD_POP_FRONT:  cell_in = from_right;
         bdq_pkg::CMD_ROTATE:     cell_in = hit ? head : from_right;
         default:                 cell_in = cell_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign q = cell_ff;

endmodule

// File: hdl/bdq_ctrl.sv
// Sequencer of the deque: element count, dump walk and result register.
`include "assert_macros.svh"
module bdq_ctrl #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  bdq_pkg::req_type                       req_data,
   input  logic signed [bdq_pkg::VALUE_W-1:0]     head_elem,
   output logic                                   busy,
   output bdq_pkg::cell_cmd_type                  cmd,
   output logic [$clog2(DEPTH)-1:0]               target,
   output logic                                   rsp_valid,
   output bdq_pkg::rsp_type                       rsp_data
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   bdq_pkg::ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type        rsp_ff, rsp_in;

   logic             accept;
   logic             full;
   logic             empty;
   logic [CNT_W-1:0] cnt_m1;
   logic             last_beat;
   logic [31:0]      occ_wide;

   assign accept    = start && (state_ff == bdq_pkg::ST_IDLE);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign cnt_m1    = count_ff - CNT_W'(1);
   assign last_beat = (idx_ff == cnt_m1[IDX_W-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (accept && req_data.action == bdq_pkg::ACT_DUMP && !empty) begin
               state_in = bdq_pkg::ST_DUMP;
            end
         end
         bdq_pkg::ST_DUMP: begin
            if (last_beat) begin
               state_in = bdq_pkg::ST_IDLE;
            end
         end
         default: state_in = bdq_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      cmd          = bdq_pkg::CMD_HOLD;
      target       = '0;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_valid_in   = 1'b1;
               rsp_in.is_last = 1'b1;
               rsp_in.status  = bdq_pkg::STATUS_DONE;
               unique case (req_data.action)
                  bdq_pkg::ACT_PUSH_FRONT: begin
                     if (full) begin
                        rsp_in.status = bdq_pkg::STATUS_FULL;
                     end else begin
                        cmd      = bdq_pkg::CMD_PUSH_FRONT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  bdq_pkg::ACT_PUSH_BACK: begin
                     if (full) begin
                        rsp_in.status = bdq_pkg::STATUS_FULL;
                     end else begin
                        cmd      = bdq_pkg::CMD_PUSH_BACK;
                        target   = count_ff[IDX_W-1:0];
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  bdq_pkg::ACT_POP_FRONT: begin
                     if (empty) begin
                        rsp_in.status = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd      = bdq_pkg::CMD_POP_FRONT;
                        count_in = cnt_m1;
                     end
                  end
                  bdq_pkg::ACT_POP_BACK: begin
                     if (empty) begin
                        rsp_in.status = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = cnt_m1;
                     end
                  end
                  bdq_pkg::ACT_DUMP: begin
                     if (empty) begin
                        rsp_in.status = bdq_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         bdq_pkg::ST_DUMP: begin
            // front element leaves cell 0 and wraps round to the back
            cmd            = bdq_pkg::CMD_ROTATE;
            target         = cnt_m1[IDX_W-1:0];
            idx_in         = idx_ff + IDX_W'(1);
            rsp_valid_in   = 1'b1;
            rsp_in.element = head_elem;
            rsp_in.is_last = last_beat;
            rsp_in.status  = bdq_pkg::STATUS_DONE;
         end
         default: ;
      endcase
      occ_wide         = 32'(count_in);
      rsp_in.occupancy = occ_wide[bdq_pkg::OCC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff == bdq_pkg::ST_DUMP);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BDQ_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CNT_W'(DEPTH)))
   `BDQ_ASSERT(a_dump_nonempty, clock, reset, busy |-> !empty)
   `BDQ_ASSERT(a_last_frees, clock, reset, (rsp_valid_ff && rsp_ff.is_last) |-> !busy)
   `BDQ_ASSERT(a_dump_entry_quiet, clock, reset, $rose(busy) |-> !rsp_valid_ff)

endmodule
